FILE: hw/rtl/bsa_pkg.sv
// Shared types and constants of the bitmap slab allocator.
// Used by the allocator top level, its divider and its checker; depends on nothing.
package bsa_pkg;

    // Field widths of the request, result and register channels
    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 17;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 2;

    // Occupancy memory word
    localparam int WORD_BITS = 8;
    localparam int BIT_W     = 3;
    localparam logic [WORD_BITS-1:0] WORD_FULL = 8'hFF;

    // Request kinds
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_LENGTH = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOC  = 3'd0,
        ST_FULL   = 3'd1,
        ST_FREED  = 3'd2,
        ST_RANGE  = 3'd3,
        ST_DOUBLE = 3'd4
    } status_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: hw/rtl/bsa_divider.sv
// Restoring divider of the bitmap slab allocator, one quotient bit per cycle.
// Depends on bsa_pkg for the address and block size widths.
module bsa_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bsa_pkg::ADDR_W-1:0]   dividend,
    input  logic [bsa_pkg::SIZE_W-1:0]   divisor,
    output logic [bsa_pkg::ADDR_W-1:0]   quotient,
    output bsa_pkg::div_status_t         stat
);
    import bsa_pkg::*;

    localparam int DCNT_W = $clog2(ADDR_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [ADDR_W-1:0] quo_reg, quo_next;
    logic [SIZE_W-1:0] dvs_reg, dvs_next;
    logic [SIZE_W:0]   rem_sh;
    logic [SIZE_W:0]   diff;
    logic              take;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[ADDR_W-1]};
        diff   = rem_sh - {1'b0, dvs_reg};
        take   = rem_sh >= {1'b0, dvs_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits the divisor width.
            quo_next = {quo_reg[ADDR_W-2:0], take};
            rem_next = take ? diff[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
            cnt_next = cnt_reg + DCNT_W'(1);
            if (cnt_reg == DCNT_W'(ADDR_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: hw/rtl/bitmap_slab_allocator.sv
// Top level of the bitmap slab allocator: occupancy memory, sequencer and result register.
// Depends on bsa_pkg and instantiates bsa_divider.
//
//  channel   signals                                  direction  content
//  s_axis    tvalid tready tdata[47:0] tuser[0]       in         request: address, func
//  m_axis    tvalid tready tdata[63:0] tuser[2:0]     out        result: block_address,
//                                                                used_count, status
//  cfg       valid ready index[1:0] data[47:0]        in         register write
//
// An allocate request reads occupancy words of eight blocks, one after another, until a
// free block turns up (at most MAX_BLOCKS / 8 rounded up words).
// A free request finds its block by a bit-serial divide of the offset.
// After reset the occupancy memory is cleared one word per cycle, during which no request
// is taken; register writes are taken at all times.
// A new request is taken while a result waits; a stalled result holds the sequencer.
module bitmap_slab_allocator #(
    parameter int MAX_BLOCKS = 1024,
    parameter int ADDR_BITS  = 48
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bsa_pkg::ADDR_W-1:0]      s_axis_tdata,   // address
    input  logic                            s_axis_tuser,   // func
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [63:0]                     m_axis_tdata,   // block_address, used_count
    output logic [bsa_pkg::STATUS_W-1:0]    m_axis_tuser,   // status
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bsa_pkg::ADDR_W-1:0]      cfg_data
);
    import bsa_pkg::*;

    localparam int WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WC_W  = $clog2(WORDS + 1);
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int PROD_W = IDX_W + SIZE_W;
    localparam logic [ADDR_W-1:0] RES_MASK =
        (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ((ADDR_W'(1) << ADDR_BITS) - ADDR_W'(1));

    typedef enum logic [11:0] {
        S_CLEAR      = 12'b0000_0000_0001,
        S_IDLE       = 12'b0000_0000_0010,
        S_SCAN_START = 12'b0000_0000_0100,
        S_SCAN       = 12'b0000_0000_1000,
        S_MUL        = 12'b0000_0001_0000,
        S_ADD        = 12'b0000_0010_0000,
        S_RANGE      = 12'b0000_0100_0000,
        S_LIMIT      = 12'b0000_1000_0000,
        S_DIV        = 12'b0001_0000_0000,
        S_FREE_RD    = 12'b0010_0000_0000,
        S_FREE_CHK   = 12'b0100_0000_0000,
        S_DONE       = 12'b1000_0000_0000
    } state_t;

    // Configuration registers
    logic [SIZE_W-1:0]  block_size_reg;
    logic [COUNT_W-1:0] block_count_reg;
    logic [ADDR_W-1:0]  region_base_reg;
    logic [ADDR_W-1:0]  region_length_reg;

    // Sequencer state
    state_t             state_reg, state_next;
    logic [WC_W-1:0]    word_reg, word_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic               m_valid_reg, m_valid_next;

    // Datapath
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [ADDR_W-1:0]  off_reg, off_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    status_t            res_status_reg, res_status_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    status_t            out_status_reg, out_status_next;
    logic [ADDR_W-1:0]  out_addr_reg, out_addr_next;
    logic [COUNT_W-1:0] out_used_reg, out_used_next;

    // Occupancy memory
    logic [WORD_BITS-1:0] bitmap_mem [WORDS];
    logic [WORD_BITS-1:0] rd_word_reg;
    logic                 mem_we, mem_re;
    logic [WA_W-1:0]      mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    // Divider
    logic                 div_start;
    logic [ADDR_W-1:0]    div_quo;
    div_status_t          div_stat;

    logic [SIZE_W-1:0]    eff_size;
    logic [CNT_W-1:0]     count_eff;
    logic [WC_W-1:0]      word_inc;
    logic [31:0]          base_bit;
    logic                 next_in_range;
    logic [WORD_BITS-1:0] valid_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [BIT_W-1:0]     lo_bit;
    logic                 found;
    logic                 out_free;

    bsa_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (off_reg),
        .divisor  (eff_size),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg    <= 17'd64;
            block_count_reg   <= 11'd1024;
            region_base_reg   <= '0;
            region_length_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BLOCK_SIZE:    block_size_reg    <= cfg_data[SIZE_W-1:0];
                CFG_BLOCK_COUNT:   block_count_reg   <= cfg_data[COUNT_W-1:0];
                CFG_REGION_BASE:   region_base_reg   <= cfg_data;
                CFG_REGION_LENGTH: region_length_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        eff_size = (block_size_reg == '0) ? SIZE_W'(1) : block_size_reg;
        if (32'(block_count_reg) < 32'(MAX_BLOCKS))
            count_eff = CNT_W'(block_count_reg);
        else
            count_eff = CNT_W'(MAX_BLOCKS);

        word_inc      = word_reg + WC_W'(1);
        base_bit      = 32'(word_reg) << BIT_W;
        next_in_range = (32'(word_inc) << BIT_W) < 32'(count_eff);

        // Blocks at or past the effective count are treated as taken.
        for (int b = 0; b < WORD_BITS; b++)
            valid_mask[b] = (base_bit + 32'(b)) < 32'(count_eff);
        free_bits = ~rd_word_reg & valid_mask;
        found     = (rd_word_reg | ~valid_mask) != WORD_FULL;
        lo_bit    = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
            if (free_bits[b])
                lo_bit = BIT_W'(b);
    end

    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        used_next       = used_reg;
        addr_next       = addr_reg;
        off_next        = off_reg;
        idx_next        = idx_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_used_next   = out_used_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        mem_we          = 1'b0;
        mem_waddr       = word_reg[WA_W-1:0];
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = word_reg[WA_W-1:0];
        div_start       = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                word_next = word_inc;
                if (word_reg == WC_W'(WORDS - 1))
                begin
                    word_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    addr_next     = s_axis_tdata;
                    res_addr_next = '0;
                    word_next     = '0;
                    if (s_axis_tuser == FUNC_ALLOC)
                        state_next = S_SCAN_START;
                    else
                        state_next = S_RANGE;
                end
            end
            S_SCAN_START:
            begin
                if (count_eff == '0)
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // rd_word_reg holds word word_reg; the next is fetched if this one is full.
                if (found)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = rd_word_reg | (WORD_BITS'(1) << lo_bit);
                    idx_next   = IDX_W'({word_reg, lo_bit});
                    used_next  = used_reg + CNT_W'(1);
                    state_next = S_MUL;
                end
                else if (next_in_range)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = word_inc[WA_W-1:0];
                    word_next  = word_inc;
                end
                else
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(idx_reg) * PROD_W'(eff_size);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                res_addr_next   = (region_base_reg + ADDR_W'(prod_reg)) & RES_MASK;
                res_status_next = ST_ALLOC;
                state_next      = S_DONE;
            end
            S_RANGE:
            begin
                if (addr_reg < region_base_reg)
                begin
                    res_status_next = ST_RANGE;
                    state_next      = S_DONE;
                end
                else
                begin
                    off_next   = addr_reg - region_base_reg;
                    state_next = S_LIMIT;
                end
            end
            S_LIMIT:
            begin
                if ((off_reg > region_length_reg) ||
                    ((region_length_reg - off_reg) < ADDR_W'(eff_size)))
                begin
                    res_status_next = ST_RANGE;
                    state_next      = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done && !div_stat.busy)
                begin
                    if (div_quo >= ADDR_W'(MAX_BLOCKS))
                    begin
                        res_status_next = ST_RANGE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        idx_next   = div_quo[IDX_W-1:0];
                        state_next = S_FREE_RD;
                    end
                end
            end
            S_FREE_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = WA_W'(idx_reg >> BIT_W);
                state_next = S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                if (!rd_word_reg[idx_reg[BIT_W-1:0]])
                    res_status_next = ST_DOUBLE;
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = WA_W'(idx_reg >> BIT_W);
                    mem_wdata = rd_word_reg & ~(WORD_BITS'(1) << idx_reg[BIT_W-1:0]);
                    if (used_reg != '0)
                        used_next = used_reg - CNT_W'(1);
                    res_status_next = ST_FREED;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    out_used_next   = COUNT_W'(used_reg);
                    m_valid_next    = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            word_reg    <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            word_reg    <= word_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        off_reg        <= off_next;
        idx_reg        <= idx_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_used_reg   <= out_used_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            bitmap_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_word_reg <= bitmap_mem[mem_raddr];
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b0, out_used_reg, out_addr_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

FILE: hw/rtl/bsa_checker.sv
// Port-level checks of the bitmap slab allocator, bound to its top level.
// Depends on bsa_pkg for the status codes.
module bsa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    import bsa_pkg::*;

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A taken request keeps the sequencer busy, so the next one is not taken right behind it.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while the previous one was still in work");

    // Only an allocation carries a block address.
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_ALLOC) |-> m_axis_tdata[47:0] == 48'd0)
        else $error("block address on a result that is not an allocation");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tuser == ST_ALLOC) || (m_axis_tuser == ST_FULL) ||
            (m_axis_tuser == ST_FREED) || (m_axis_tuser == ST_RANGE) ||
            (m_axis_tuser == ST_DOUBLE))
        else $error("result status outside the defined codes");

endmodule

bind bitmap_slab_allocator bsa_checker u_bsa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/tb_bitmap_slab_allocator.sv
// Self-checking testbench for the bitmap slab allocator: issues allocate and free requests
// under a sequence of register settings and compares every result with its own prediction.
// Depends on bsa_pkg and bitmap_slab_allocator.
`timescale 1ns / 1ps

module tb_bitmap_slab_allocator;
    import bsa_pkg::*;

    localparam int MAX_BLOCKS   = 1024;
    localparam int PHASES       = 13;
    localparam int PHASE_ITEMS  = 130;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 8;
    localparam int DRAIN_CYCLES = 150;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  block_address;
        logic [COUNT_W-1:0] used_count;
    } outcome_t;

    // Mirror of the allocator: registers, occupancy bits and the results still owed.
    class alloc_tracker;
        logic [SIZE_W-1:0]  block_size;
        logic [COUNT_W-1:0] block_count;
        logic [ADDR_W-1:0]  region_base;
        logic [ADDR_W-1:0]  region_length;
        bit                 in_use[MAX_BLOCKS];
        int                 used_blocks;
        int                 errors;
        outcome_t           outcomes_due[$];

        function new();
            block_size    = 64;
            block_count   = 1024;
            region_base   = '0;
            region_length = '0;
            foreach (in_use[i])
                in_use[i] = 1'b0;
            used_blocks = 0;
            errors      = 0;
        endfunction

        // A block size of zero is treated as one byte.
        function logic [ADDR_W-1:0] block_bytes();
            return (block_size == 0) ? ADDR_W'(1) : ADDR_W'(block_size);
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
            case (idx)
                CFG_BLOCK_SIZE:    block_size    = val[SIZE_W-1:0];
                CFG_BLOCK_COUNT:   block_count   = val[COUNT_W-1:0];
                CFG_REGION_BASE:   region_base   = val;
                CFG_REGION_LENGTH: region_length = val;
                default: ;
            endcase
        endfunction

        function int find_block(bit want, int start);
            for (int n = 0; n < MAX_BLOCKS; n++)
                if (in_use[(start + n) % MAX_BLOCKS] == want)
                    return (start + n) % MAX_BLOCKS;
            return -1;
        endfunction

        function void note_request(logic func, logic [ADDR_W-1:0] addr);
            outcome_t          o;
            logic [ADDR_W-1:0] bytes;
            logic [ADDR_W-1:0] offset;
            logic [ADDR_W-1:0] index;
            int                lim;
            bit                found;
            bytes           = block_bytes();
            o.status        = ST_FULL;
            o.block_address = '0;
            found           = 1'b0;
            if (func == FUNC_ALLOC) begin
                lim = (block_count < MAX_BLOCKS) ? int'(block_count) : MAX_BLOCKS;
                for (int i = 0; i < lim && !found; i++) begin
                    if (!in_use[i]) begin
                        in_use[i] = 1'b1;
                        used_blocks++;
                        o.status        = ST_ALLOC;
                        o.block_address = region_base + ADDR_W'(i) * bytes;
                        found           = 1'b1;
                    end
                end
            end else if (addr < region_base) begin
                o.status = ST_RANGE;
            end else begin
                offset = addr - region_base;
                // The range check must not wrap, hence the subtraction on the length side.
                if (offset > region_length || region_length - offset < bytes) begin
                    o.status = ST_RANGE;
                end else begin
                    index = offset / bytes;
                    if (index >= MAX_BLOCKS) begin
                        o.status = ST_RANGE;
                    end else if (!in_use[index]) begin
                        o.status = ST_DOUBLE;
                    end else begin
                        in_use[index] = 1'b0;
                        if (used_blocks > 0)
                            used_blocks--;
                        o.status = ST_FREED;
                    end
                end
            end
            o.used_count = COUNT_W'(used_blocks);
            outcomes_due.push_back(o);
        endfunction

        function void check_result(logic [63:0] data, logic [STATUS_W-1:0] kind);
            outcome_t o;
            if (outcomes_due.size() == 0) begin
                $error("result with no request outstanding: status %0d", kind);
                errors++;
            end else begin
                o = outcomes_due.pop_front();
                if (kind !== o.status) begin
                    $error("status: expected %0d, got %0d", o.status, kind);
                    errors++;
                end
                if (data[ADDR_W-1:0] !== o.block_address) begin
                    $error("block_address: expected %h, got %h",
                           o.block_address, data[ADDR_W-1:0]);
                    errors++;
                end
                if (data[ADDR_W +: COUNT_W] !== o.used_count) begin
                    $error("used_count: expected %0d, got %0d",
                           o.used_count, data[ADDR_W +: COUNT_W]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [ADDR_W-1:0]    s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [63:0]          m_axis_tdata;
    logic [STATUS_W-1:0]  m_axis_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    bit quiet;
    bit hold_off_req;
    int cycle_count;

    alloc_tracker tracker = new();

    bitmap_slab_allocator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [ADDR_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ADDR_W-1:0];
    endfunction

    // The valid line stays high between back-to-back requests and drops only for a gap.
    task automatic offer_request(input logic func, input logic [ADDR_W-1:0] addr);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= addr;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        tracker.note_request(func, addr);
    endtask

    task automatic wait_idle(input int extra);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.outcomes_due.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.set_register(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Registers change only once every owed result has come back.
    // Unused upper data bits are sometimes filled with noise.
    task automatic configure(input logic [SIZE_W-1:0] size, input logic [COUNT_W-1:0] count,
                             input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] length);
        logic [ADDR_W-1:0] junk;
        wait_idle(SETTLE);
        junk = rand48();
        write_reg(CFG_BLOCK_SIZE, ($urandom_range(0, 3) == 0) ?
                  {junk[ADDR_W-1:SIZE_W], size} : ADDR_W'(size));
        junk = rand48();
        write_reg(CFG_BLOCK_COUNT, ($urandom_range(0, 3) == 0) ?
                  {junk[ADDR_W-1:COUNT_W], count} : ADDR_W'(count));
        write_reg(CFG_REGION_BASE, base);
        write_reg(CFG_REGION_LENGTH, length);
    endtask

    task automatic configure_random();
        logic [SIZE_W-1:0]  size;
        logic [COUNT_W-1:0] count;
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  length;
        logic [63:0]        span;
        int                 eff_size;
        int                 eff_count;
        case ($urandom_range(0, 7))
            0:       size = '0;
            1:       size = 1;
            2:       size = '1;
            3:       size = 65536;
            4, 5:    size = SIZE_W'($urandom_range(1, 64));
            6:       size = SIZE_W'($urandom_range(1, 4096));
            default: size = SIZE_W'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       count = '0;
            1:       count = '1;
            2:       count = 1024;
            3:       count = 1;
            default: count = COUNT_W'($urandom_range(2, 96));
        endcase
        case ($urandom_range(0, 5))
            0:       base = '0;
            1:       base = ADDR_MAX - ADDR_W'($urandom_range(0, 1 << 20));
            2, 3:    base = rand48();
            default: base = ADDR_W'($urandom_range(0, 1 << 24));
        endcase
        eff_size  = (size == 0) ? 1 : int'(size);
        eff_count = (count < MAX_BLOCKS) ? int'(count) : MAX_BLOCKS;
        case ($urandom_range(0, 5))
            0:       length = '0;
            1:       length = ADDR_MAX;
            2:       length = rand48();
            default:
            begin
                // Roughly the span of the usable blocks, a little short or a little over.
                span = 64'(eff_count) * 64'(eff_size) + 64'($urandom_range(0, 2 * eff_size));
                span = (span > 64'(eff_size)) ? span - 64'(eff_size) : 64'd0;
                length = (span > 64'(ADDR_MAX)) ? ADDR_MAX : span[ADDR_W-1:0];
            end
        endcase
        configure(size, count, base, length);
    endtask

    task automatic random_free();
        logic [ADDR_W-1:0] bytes;
        logic [ADDR_W-1:0] addr;
        int                kind;
        int                idx;
        bytes = tracker.block_bytes();
        kind  = $urandom_range(0, 9);
        if (kind < 8)
        begin
            // Mostly blocks in use, some already free ones to provoke double frees.
            idx = tracker.find_block(kind < 6, $urandom_range(0, MAX_BLOCKS - 1));
            if (idx < 0)
                addr = rand48();
            else
                addr = tracker.region_base + ADDR_W'(idx) * bytes
                       + ADDR_W'($urandom_range(0, int'(bytes) - 1));
        end
        else if (kind == 8)
        begin
            addr = rand48();
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            addr = tracker.region_base - ADDR_W'($urandom_range(1, 3));
        end
        else
        begin
            addr = tracker.region_base + tracker.region_length
                   - ADDR_W'($urandom_range(0, 2 * int'(bytes)));
        end
        offer_request(FUNC_FREE, addr);
    endtask

    // Result side: short random stalls, and one long hold-off on request.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tdata, m_axis_tuser);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL bitmap_slab_allocator");
        $finish;
    end

    initial
    begin
        int bias;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_ALLOC;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_BLOCK_SIZE;
        cfg_data      = '0;
        quiet         = 1'b0;
        hold_off_req  = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: the region has zero length, so every free is out of range.
        offer_request(FUNC_ALLOC, '0);
        offer_request(FUNC_ALLOC, ADDR_MAX);
        offer_request(FUNC_FREE, '0);
        offer_request(FUNC_FREE, ADDR_MAX);

        // Zero block size acts as one byte; four blocks, sixteen bytes of region.
        configure('0, 4, 48'h1000, 48'h10);
        offer_request(FUNC_ALLOC, rand48());
        offer_request(FUNC_ALLOC, rand48());
        offer_request(FUNC_ALLOC, rand48());
        offer_request(FUNC_FREE, 48'h1001);
        offer_request(FUNC_FREE, 48'h1001);
        offer_request(FUNC_FREE, 48'h0FFF);
        offer_request(FUNC_FREE, 48'h1010);
        offer_request(FUNC_FREE, 48'h1006);
        offer_request(FUNC_ALLOC, rand48());

        // Largest block size with a base near the top of the address range.
        configure('1, '1, 48'hFFFF_FFFA_0000, ADDR_MAX);
        offer_request(FUNC_ALLOC, rand48());
        offer_request(FUNC_FREE, 48'h0001_FFFC);
        offer_request(FUNC_FREE, 48'hFFFF_FFFF_FFFE);
        offer_request(FUNC_ALLOC, rand48());

        configure(1, 8, '0, ADDR_MAX);
        offer_request(FUNC_ALLOC, rand48());
        offer_request(FUNC_ALLOC, rand48());
        offer_request(FUNC_ALLOC, rand48());

        // A block above a lowered count can still be freed; the storage limit still holds.
        configure(1, 2, '0, ADDR_MAX);
        offer_request(FUNC_FREE, 48'd6);
        offer_request(FUNC_ALLOC, rand48());
        offer_request(FUNC_FREE, 48'd1024);
        offer_request(FUNC_FREE, ADDR_MAX);

        configure(1, '0, '0, ADDR_MAX);
        offer_request(FUNC_ALLOC, rand48());

        for (int p = 0; p < PHASES; p++)
        begin
            configure_random();
            if (p == PHASES - 1)
                quiet = 1'b1;
            if (p == 2)
                hold_off_req = 1'b1;
            bias = $urandom_range(20, 80);
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < bias)
                    offer_request(FUNC_ALLOC, rand48());
                else
                    random_free();
            end
        end

        wait_idle(DRAIN_CYCLES);
        if (tracker.errors == 0)
            $display("PASS bitmap_slab_allocator");
        else
            $display("FAIL bitmap_slab_allocator");
        $finish;
    end

endmodule
